// ===== sv/pse_pkg.sv =====
// Shared types, constants and operator codes for the postfix stack evaluator
`default_nettype none
package pse_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic CMD_NUM = 1'b0;
  localparam logic CMD_OP  = 1'b1;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MOD  = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNDER   = 3'd1;
  localparam logic [2:0] ERR_OVER    = 3'd2;
  localparam logic [2:0] ERR_DIVZERO = 3'd3;
  localparam logic [2:0] ERR_NEGEXP  = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [30:0] token_value;
    logic [2:0]  operator_code;
    logic        last_token;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         error_code;
  } out_word_t;

endpackage
`default_nettype wire

// ===== sv/pse_fifo.sv =====
// Two-entry token queue between the front and back parts
`default_nettype none
module pse_fifo (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic push,
  input  wire pse_pkg::in_word_t din,
  output logic               full,
  input  wire                logic pop,
  output logic               empty,
  output pse_pkg::in_word_t  dout
);
  pse_pkg::in_word_t mem_r [pse_pkg::FIFO_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule
`default_nettype wire

// ===== sv/pse_alu.sv =====
// Multi-cycle arithmetic unit: add, subtract, multiply, divide, modulo, power
`default_nettype none
module pse_alu (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        start,
  input  wire  logic [2:0]  op,
  input  wire  logic [31:0] a,
  input  wire  logic [31:0] b,
  output logic              done,
  output logic [31:0]       res,
  output logic [2:0]        err
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_POW  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  st_r;
  logic [5:0]  n_r;
  logic [31:0] q_r, rm_r, dv_r, acc_r, base_r, e_r, res_r;
  logic [2:0]  err_r, op_r;
  logic        qneg_r, rneg_r, done_r;
  logic [32:0] trial;
  logic [31:0] absa, absb;

  assign absa  = a[31] ? -a : a;
  assign absb  = b[31] ? -b : b;
  assign trial = {rm_r, q_r[31]} - {1'b0, dv_r};
  assign done = done_r;
  assign res  = res_r;
  assign err  = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == S_FIN);
      case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            case (op)
              pse_pkg::OP_ADD: begin
                res_r <= a + b; err_r <= pse_pkg::ERR_NONE; st_r <= S_FIN;
              end
              pse_pkg::OP_SUB: begin
                res_r <= a - b; err_r <= pse_pkg::ERR_NONE; st_r <= S_FIN;
              end
              pse_pkg::OP_MUL: begin
                res_r <= a * b; err_r <= pse_pkg::ERR_NONE; st_r <= S_FIN;
              end
              pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
                if (b == 32'd0) begin
                  res_r <= 32'd0; err_r <= pse_pkg::ERR_DIVZERO; st_r <= S_FIN;
                end else begin
                  err_r  <= pse_pkg::ERR_NONE;
                  q_r    <= absa;
                  rm_r   <= 32'd0;
                  dv_r   <= absb;
                  qneg_r <= a[31] ^ b[31];
                  rneg_r <= a[31];
                  n_r    <= 6'd32;
                  st_r   <= S_DIV;
                end
              end
              pse_pkg::OP_POW: begin
                if (b[31]) begin
                  res_r <= 32'd0; err_r <= pse_pkg::ERR_NEGEXP; st_r <= S_FIN;
                end else begin
                  err_r  <= pse_pkg::ERR_NONE;
                  acc_r  <= 32'd1;
                  base_r <= a;
                  e_r    <= b;
                  st_r   <= S_POW;
                end
              end
              default: begin
                res_r <= 32'd0; err_r <= pse_pkg::ERR_NONE; st_r <= S_FIN;
              end
            endcase
          end
        end
        S_DIV: begin
          if (!trial[32]) begin
            rm_r <= trial[31:0];
            q_r  <= {q_r[30:0], 1'b1};
          end else begin
            rm_r <= {rm_r[30:0], q_r[31]};
            q_r  <= {q_r[30:0], 1'b0};
          end
          n_r <= n_r - 6'd1;
          if (n_r == 6'd1) begin
            st_r <= S_FIN;
          end
        end
        S_POW: begin
          if (e_r == 32'd0) begin
            res_r <= acc_r;
            st_r  <= S_FIN;
          end else begin
            if (e_r[0]) begin
              acc_r <= acc_r * base_r;
            end
            base_r <= base_r * base_r;
            e_r    <= e_r >> 1;
          end
        end
        S_FIN: begin
          if (err_r == pse_pkg::ERR_NONE && op_r == pse_pkg::OP_DIV) begin
            res_r <= qneg_r ? -q_r : q_r;
          end else if (err_r == pse_pkg::ERR_NONE && op_r == pse_pkg::OP_MOD) begin
            res_r <= rneg_r ? -rm_r : rm_r;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/pse_exec.sv =====
// Back part: operand stack, sticky error and result queue
`default_nettype none
module pse_exec #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              tok_empty,
  input  wire  pse_pkg::in_word_t tok,
  output logic                    tok_pop,
  output logic                    out_empty,
  input  wire  logic              out_pop,
  output pse_pkg::out_word_t      out_word
);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_ALU  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_TOP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [31:0]   stk_r [STACK_DEPTH];
  logic [31:0]   rd_r, opb_r, opa_r;
  logic [2:0]    st_r, err_r, opc_r;
  logic [CW-1:0] cnt_r;
  logic          last_r, wr_en, alu_go_r, alu_done, ov_r;
  logic [AW-1:0] wr_a, rd_a;
  logic [31:0]   wr_d, alu_res;
  logic [2:0]    alu_err;
  pse_pkg::out_word_t ow_r;

  pse_alu u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_go_r), .op(opc_r),
    .a(opa_r), .b(opb_r), .done(alu_done), .res(alu_res), .err(alu_err)
  );

  assign out_empty = !ov_r;
  assign out_word  = ow_r;
  assign tok_pop   = (st_r == S_IDLE) && !tok_empty;

  always_comb begin
    wr_en = 1'b0;
    wr_a  = cnt_r[AW-1:0];
    wr_d  = {1'b0, tok.token_value};
    rd_a  = cnt_r[AW-1:0] - AW'(1);
    if (tok_pop && tok.cmd == pse_pkg::CMD_NUM && cnt_r < DEPTH_C) begin
      wr_en = 1'b1;
    end
    if (st_r == S_FIN) begin
      wr_en = 1'b1;
      wr_a  = cnt_r[AW-1:0] - AW'(2);
      wr_d  = alu_res;
    end
    if (st_r == S_RD1) begin
      rd_a = cnt_r[AW-1:0] - AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_r[wr_a] <= wr_d;
    end
    rd_r <= stk_r[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      err_r    <= pse_pkg::ERR_NONE;
      ov_r     <= 1'b0;
      alu_go_r <= 1'b0;
    end else begin
      alu_go_r <= (st_r == S_RD2);
      if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (tok_pop) begin
            last_r <= tok.last_token;
            opc_r  <= tok.operator_code;
            if (tok.cmd == pse_pkg::CMD_NUM) begin
              if (cnt_r < DEPTH_C) begin
                cnt_r <= cnt_r + CW'(1);
              end else if (err_r == pse_pkg::ERR_NONE) begin
                err_r <= pse_pkg::ERR_OVER;
              end
              st_r <= tok.last_token ? S_TOP : S_IDLE;
            end else if (cnt_r < CW'(2)) begin
              if (err_r == pse_pkg::ERR_NONE) begin
                err_r <= pse_pkg::ERR_UNDER;
              end
              st_r <= tok.last_token ? S_TOP : S_IDLE;
            end else begin
              st_r <= S_RD1;
            end
          end
        end
        S_RD1: begin
          opb_r <= rd_r;
          st_r  <= S_RD2;
        end
        S_RD2: begin
          opa_r <= rd_r;
          st_r  <= S_ALU;
        end
        S_ALU: begin
          if (alu_done) begin
            if (err_r == pse_pkg::ERR_NONE) begin
              err_r <= alu_err;
            end
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          cnt_r <= cnt_r - CW'(1);
          st_r  <= last_r ? S_TOP : S_IDLE;
        end
        S_TOP: begin
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r) begin
            ow_r.error_code   <= (cnt_r == '0 && err_r == pse_pkg::ERR_NONE)
                                 ? pse_pkg::ERR_UNDER : err_r;
            ow_r.result_value <= (cnt_r == '0 || err_r != pse_pkg::ERR_NONE)
                                 ? 32'sd0 : rd_r;
            ov_r  <= 1'b1;
            cnt_r <= '0;
            err_r <= pse_pkg::ERR_NONE;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator
//
// Input queue: drive in_word and push; a word is taken on a clock edge with
// push high and full low. A two-entry token queue decouples the front from
// the stack engine, so tokens may be pushed while the engine is busy; the
// engine takes a word from the queue whenever it is idle.
// Result queue: a result word waits on out_word while empty is low and is
// taken on an edge with pop high. One result appears per token marked last.
// A number token is written onto the stack (a last token also reads the top).
// Add, subtract, multiply and the unused codes go straight to the ALU's finish
// state; divide and modulo run the one-bit-per-cycle divider, and power runs
// the square-and-multiply loop over the exponent bits. One token is worked
// at a time. While a result is not popped, the engine holds before writing
// the next result and the token queue fills, raising full.
// Synchronous active-low reset empties both queues, clears the stack count
// and the sticky error. Stack contents are not cleared.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              push,
  output logic                    full,
  input  wire  pse_pkg::in_word_t in_word,
  output logic                    empty,
  input  wire  logic              pop,
  output pse_pkg::out_word_t      out_word
);
  logic              q_empty, q_pop;
  pse_pkg::in_word_t q_word;

  pse_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(in_word), .full(full),
    .pop(q_pop), .empty(q_empty), .dout(q_word)
  );

  pse_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
    .clk(clk), .rst_n(rst_n), .tok_empty(q_empty), .tok(q_word),
    .tok_pop(q_pop), .out_empty(empty), .out_pop(pop), .out_word(out_word)
  );
endmodule
`default_nettype wire

// ===== tb/postfix_stack_evaluator_checker.sv =====
// Checker for the postfix stack evaluator: predicts results from accepted tokens and compares
`default_nettype none
module postfix_stack_evaluator_checker #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic               full,
  input  wire pse_pkg::in_word_t  in_word,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire pse_pkg::out_word_t out_word,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);
  logic [31:0]        eval_stack [STACK_DEPTH];
  int unsigned        depth_held;
  logic [2:0]         held_error;
  pse_pkg::out_word_t expected_results [$];

  function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] expo);
    logic [31:0] acc;
    acc = 32'd1;
    while (expo != 0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  task automatic flag_error(logic [2:0] code);
    if (held_error == pse_pkg::ERR_NONE) held_error = code;
  endtask

  task automatic evaluate_token(pse_pkg::in_word_t w);
    logic signed [31:0] a, b;
    logic [31:0] r;
    pse_pkg::out_word_t res;
    if (w.cmd == pse_pkg::CMD_NUM) begin
      if (depth_held >= STACK_DEPTH) flag_error(pse_pkg::ERR_OVER);
      else begin
        eval_stack[depth_held] = {1'b0, w.token_value};
        depth_held++;
      end
    end else if (depth_held < 2) begin
      flag_error(pse_pkg::ERR_UNDER);
    end else begin
      b = eval_stack[depth_held-1];
      a = eval_stack[depth_held-2];
      r = 32'd0;
      case (w.operator_code)
        pse_pkg::OP_ADD: r = a + b;
        pse_pkg::OP_SUB: r = a - b;
        pse_pkg::OP_MUL: r = a * b;
        pse_pkg::OP_DIV: begin
          if (b == 0) flag_error(pse_pkg::ERR_DIVZERO);
          else if (a == 32'sh80000000 && b == -1) r = a;
          else r = a / b;
        end
        pse_pkg::OP_MOD: begin
          if (b == 0) flag_error(pse_pkg::ERR_DIVZERO);
          else if (a == 32'sh80000000 && b == -1) r = 32'd0;
          else r = a % b;
        end
        pse_pkg::OP_POW: begin
          if (b < 0) flag_error(pse_pkg::ERR_NEGEXP);
          else r = wrap_power(a, b);
        end
        default: r = 32'd0;
      endcase
      eval_stack[depth_held-2] = r;
      depth_held--;
    end
    if (w.last_token) begin
      res.result_value = 32'd0;
      if (depth_held == 0) flag_error(pse_pkg::ERR_UNDER);
      else if (held_error == pse_pkg::ERR_NONE) res.result_value = eval_stack[depth_held-1];
      if (held_error != pse_pkg::ERR_NONE) res.result_value = 32'd0;
      res.error_code = held_error;
      expected_results.push_back(res);
      depth_held = 0;
      held_error = pse_pkg::ERR_NONE;
    end
  endtask

  always @(posedge clk) begin
    pse_pkg::out_word_t want;
    if (!rst_n) begin
      depth_held = 0;
      held_error = pse_pkg::ERR_NONE;
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (pop && !empty) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %0d err %0d",
                                        out_word.result_value, out_word.error_code);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_word) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d err %0d, got %0d err %0d",
                       want.result_value, want.error_code,
                       out_word.result_value, out_word.error_code);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) evaluate_token(in_word);
    end
    pending_count <= expected_results.size();
  end
endmodule
`default_nettype wire

// ===== tb/postfix_stack_evaluator_tb.sv =====
// Testbench top for the postfix stack evaluator: stimulus, idling phases and verdict
`default_nettype none
module postfix_stack_evaluator_tb;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk, rst_n, push, pop, full, empty;
  pse_pkg::in_word_t  in_word;
  pse_pkg::out_word_t out_word;
  int                 fail_count, pending_count, result_count;
  int                 send_idle, recv_idle, idle_cycles, tokens_sent;
  pse_pkg::in_word_t  token_queue [$];

  postfix_stack_evaluator dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word)
  );

  postfix_stack_evaluator_checker chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic pse_pkg::in_word_t num_tok(logic [30:0] v, logic last);
    pse_pkg::in_word_t w;
    w = '0;
    w.cmd = pse_pkg::CMD_NUM; w.token_value = v; w.last_token = last;
    w.operator_code = 3'($urandom_range(0, 7));
    return w;
  endfunction

  function automatic pse_pkg::in_word_t op_tok(logic [2:0] code, logic last);
    pse_pkg::in_word_t w;
    w.cmd = pse_pkg::CMD_OP; w.operator_code = code; w.last_token = last;
    w.token_value = 31'($urandom);
    return w;
  endfunction

  function automatic logic [30:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 3));
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(0, 40));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic binary_expr(logic [30:0] a, logic [30:0] b, logic [2:0] code);
    token_queue.push_back(num_tok(a, 0));
    token_queue.push_back(num_tok(b, 0));
    token_queue.push_back(op_tok(code, 1));
  endtask

  task automatic build_directed();
    int i;
    for (i = 0; i < 6; i++) binary_expr(31'h7fffffff, 31'd3, 3'(i));
    binary_expr(31'd5, 31'd0, pse_pkg::OP_DIV);
    binary_expr(31'd0, 31'd0, pse_pkg::OP_POW);
    token_queue.push_back(op_tok(pse_pkg::OP_ADD, 1));
    token_queue.push_back(num_tok(31'd9, 0));
    token_queue.push_back(op_tok(pse_pkg::OP_RSV6, 0));
    token_queue.push_back(num_tok(31'd1, 0));
    token_queue.push_back(op_tok(pse_pkg::OP_RSV7, 1));
    token_queue.push_back(num_tok(31'd0, 1));
    token_queue.push_back(num_tok(31'd2, 0));
    token_queue.push_back(num_tok(31'd1, 0));
    token_queue.push_back(num_tok(31'd5, 0));
    token_queue.push_back(op_tok(pse_pkg::OP_SUB, 0));
    token_queue.push_back(op_tok(pse_pkg::OP_POW, 1));
    for (i = 0; i < 2; i++) begin
      token_queue.push_back(num_tok(31'h7fffffff, 0));
      token_queue.push_back(num_tok(31'd1, 0));
      token_queue.push_back(op_tok(pse_pkg::OP_ADD, 0));
      token_queue.push_back(num_tok(31'd0, 0));
      token_queue.push_back(num_tok(31'd1, 0));
      token_queue.push_back(op_tok(pse_pkg::OP_SUB, 0));
      token_queue.push_back(op_tok((i == 0) ? pse_pkg::OP_DIV : pse_pkg::OP_MOD, 1));
    end
  endtask

  // random expression: mostly well formed, with overflow, underflow and negative operands
  task automatic build_random_expr();
    int len, depth, i, kind;
    pse_pkg::in_word_t w;
    kind = $urandom_range(0, 9);
    len = (kind == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
    depth = 0;
    for (i = 0; i < len; i++) begin
      if (kind == 0) w = num_tok(rand_value(), 0);
      else if (kind == 1) w = ($urandom_range(0, 1)) ? num_tok(rand_value(), 0)
                                                   : op_tok(3'($urandom), 0);
      else if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < 6)) begin
        w = num_tok(rand_value(), 0); depth++;
      end else begin
        w = op_tok(($urandom_range(0, 12) > 11)
                   ? (($urandom_range(0, 1) == 0) ? pse_pkg::OP_RSV6 : pse_pkg::OP_RSV7)
                   : 3'($urandom_range(0, 5)), 0);
        depth--;
      end
      token_queue.push_back(w);
    end
    if (kind > 1) while (depth > 1) begin
      token_queue.push_back(op_tok(3'($urandom_range(0, 5)), 0));
      depth--;
    end
    w = token_queue.pop_back();
    w.last_token = 1'b1;
    token_queue.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_all();
    while (token_queue.size() > 0) begin
      @(posedge clk);
      if (push && !full) begin
        tokens_sent++;
        void'(token_queue.pop_front());
      end
      if (token_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        push <= 1'b1;
        in_word <= token_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0 || !empty) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int phase, n;
    rst_n = 0; push = 0; in_word = '0;
    send_idle = 0; recv_idle = 0; tokens_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    build_directed();
    send_all();
    drain();
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 8 : (phase == 1) ? 70 : 0;
      recv_idle = (phase == 0) ? 70 : (phase == 1) ? 8 : 0;
      n = tokens_sent;
      while (tokens_sent - n < 155) begin
        build_random_expr();
        send_all();
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
    end
    $display("Sent %0d tokens over three idling phases, checked %0d results", tokens_sent,
             result_count);
    $display("including overflow, underflow, division by zero and negative exponents");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
